[hdl/packet_framer_crc16_core_defines.svh]
// ---------------------------------------------------------------------------
// Packet framer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_FRAMER_CRC16_CORE_DEFINES_SVH
`define PACKET_FRAMER_CRC16_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packet framer check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packet framer check failed");

`endif

[hdl/pfc_pkg.sv]
// ---------------------------------------------------------------------------
// Packet framer package
// Beat types, codes and the CRC-16/MODBUS byte step.
// ---------------------------------------------------------------------------
package pfc_pkg;

	localparam int BURST_MAX = 7;
	localparam int CNT_W     = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] SYNC_RESET = 8'd170;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	localparam logic CFG_SYNC    = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LONG  = 2'd1,
		ST_NO_PACKET = 2'd2,
		ST_IN_PACKET = 2'd3
	} status_t;

	// What a queued output beat carries
	typedef enum logic [1:0] {
		K_BYTE   = 2'd0,
		K_CRC_LO = 2'd1,
		K_CRC_HI = 2'd2,
		K_ERR    = 2'd3
	} kind_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_packet;
		status_t    status;
	} result_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		status_t    status;
	} entry_t;

	typedef struct packed {
		entry_t [BURST_MAX-1:0] ent;
		logic [CNT_W-1:0]       count;
	} burst_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hdl/pfc_frame.sv]
// ---------------------------------------------------------------------------
// Packet framer front end
// Input register and packet state; turns one item into a burst of beats.
// ---------------------------------------------------------------------------
module pfc_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  pfc_pkg::item_t  item,
	input  logic [7:0]      sync_value,
	input  logic [15:0]     max_payload_length,
	input  logic            take,
	output logic            load_valid,
	output pfc_pkg::burst_t burst
);

	pfc_pkg::item_t item_s1;
	logic           valid_s1;
	logic           adv;

	logic [15:0] seq_q, seq_d;
	logic [15:0] remain_q, remain_d;
	logic        open_q, open_d;

	assign adv        = valid_s1 && take;
	assign item_ready = !valid_s1 || take;
	assign load_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		burst    = '0;
		seq_d    = seq_q;
		remain_d = remain_q;
		open_d   = open_q;
		for (int i = 0; i < pfc_pkg::BURST_MAX; i++) begin
			burst.ent[i].kind   = pfc_pkg::K_ERR;
			burst.ent[i].data   = 8'h00;
			burst.ent[i].status = pfc_pkg::ST_OK;
		end
		if (item_s1.operation == pfc_pkg::OP_START) begin
			if (open_q) begin
				burst.ent[0].status = pfc_pkg::ST_IN_PACKET;
				burst.count         = pfc_pkg::CNT_W'(1);
			end else if (item_s1.payload_length > max_payload_length) begin
				burst.ent[0].status = pfc_pkg::ST_TOO_LONG;
				burst.count         = pfc_pkg::CNT_W'(1);
			end else begin
				for (int i = 0; i < 5; i++) begin
					burst.ent[i].kind = pfc_pkg::K_BYTE;
				end
				burst.ent[0].data = sync_value;
				burst.ent[1].data = item_s1.payload_length[7:0];
				burst.ent[2].data = item_s1.payload_length[15:8];
				burst.ent[3].data = seq_q[7:0];
				burst.ent[4].data = seq_q[15:8];
				if (item_s1.payload_length == 16'd0) begin
					// empty payload: close at once with the trailer
					burst.ent[5].kind = pfc_pkg::K_CRC_LO;
					burst.ent[6].kind = pfc_pkg::K_CRC_HI;
					burst.count       = pfc_pkg::CNT_W'(7);
					seq_d             = seq_q + 16'd1;
				end else begin
					burst.count = pfc_pkg::CNT_W'(5);
					remain_d    = item_s1.payload_length;
					open_d      = 1'b1;
				end
			end
		end else begin
			if (!open_q) begin
				burst.ent[0].status = pfc_pkg::ST_NO_PACKET;
				burst.count         = pfc_pkg::CNT_W'(1);
			end else begin
				burst.ent[0].kind = pfc_pkg::K_BYTE;
				burst.ent[0].data = item_s1.payload_byte;
				remain_d          = remain_q - 16'd1;
				if (remain_q == 16'd1) begin
					burst.ent[1].kind = pfc_pkg::K_CRC_LO;
					burst.ent[2].kind = pfc_pkg::K_CRC_HI;
					burst.count       = pfc_pkg::CNT_W'(3);
					open_d            = 1'b0;
					seq_d             = seq_q + 16'd1;
				end else begin
					burst.count = pfc_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= 16'd0;
			remain_q <= 16'd0;
			open_q   <= 1'b0;
		end else if (adv) begin
			seq_q    <= seq_d;
			remain_q <= remain_d;
			open_q   <= open_d;
		end
	end

endmodule

[hdl/pfc_serial.sv]
// ---------------------------------------------------------------------------
// Packet framer output stage
// Beat queue shifted out one per cycle while result_ready is high, with the running CRC over sent bytes.
// ---------------------------------------------------------------------------
module pfc_serial (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	input  pfc_pkg::burst_t  burst,
	output logic             take,
	output logic             result_valid,
	input  logic             result_ready,
	output pfc_pkg::result_t result
);

	pfc_pkg::entry_t [pfc_pkg::BURST_MAX-1:0] ent_q;
	logic [pfc_pkg::CNT_W-1:0]                cnt_q;
	logic [15:0]                              crc_q;
	logic                                     load;
	logic                                     beat;

	assign result_valid = (cnt_q != '0);
	assign beat         = result_valid && result_ready;
	// free now, or the last queued beat leaves this cycle
	assign take = (cnt_q == '0) || ((cnt_q == pfc_pkg::CNT_W'(1)) && result_ready);
	assign load = load_valid && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
		end else if (beat) begin
			cnt_q <= cnt_q - pfc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= burst.ent;
		end else if (beat) begin
			for (int i = 0; i < pfc_pkg::BURST_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	// CRC advances on each byte as it leaves; the high trailer byte rearms it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= pfc_pkg::CRC_INIT;
		end else if (beat) begin
			case (ent_q[0].kind)
				pfc_pkg::K_BYTE:   crc_q <= pfc_pkg::crc16_byte(crc_q, ent_q[0].data);
				pfc_pkg::K_CRC_HI: crc_q <= pfc_pkg::CRC_INIT;
				default:           crc_q <= crc_q;
			endcase
		end
	end

	always_comb begin
		case (ent_q[0].kind)
			pfc_pkg::K_BYTE:   result.out_byte = ent_q[0].data;
			pfc_pkg::K_CRC_LO: result.out_byte = crc_q[7:0];
			pfc_pkg::K_CRC_HI: result.out_byte = crc_q[15:8];
			default:           result.out_byte = 8'h00;
		endcase
		result.last_of_packet = (ent_q[0].kind == pfc_pkg::K_CRC_HI);
		result.status         = ent_q[0].status;
	end

endmodule

[hdl/packet_framer_crc16_core.sv]
// An accepted item waits in the front-end input register, then loads into the beat
// queue; one result beat per cycle leaves the queue head while result_ready is high;
// a data item gives 1 beat (3 when it closes the packet), a start 5 or 7, an error 1.
// The queue takes the next item only when it is empty or as its last beat leaves.
// Reset clears packet state, sequence number, CRC, queue and config to defaults.
// ---------------------------------------------------------------------------
// Packet framer with CRC-16/MODBUS trailer; bad items give an error beat
// Frames start and data items into sync, length, sequence, payload and CRC bytes.
// ---------------------------------------------------------------------------
`include "packet_framer_crc16_core_defines.svh"

module packet_framer_crc16_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pfc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pfc_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data
);

	logic [7:0]      sync_q;
	logic [15:0]     max_len_q;
	logic            take;
	logic            load_valid;
	pfc_pkg::burst_t burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= pfc_pkg::SYNC_RESET;
			max_len_q <= pfc_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfc_pkg::CFG_SYNC:    sync_q    <= cfg_data[7:0];
				pfc_pkg::CFG_MAX_LEN: max_len_q <= cfg_data;
				default:              sync_q    <= sync_q;
			endcase
		end
	end

	pfc_frame u_frame (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_ready         (item_ready),
		.item               (item),
		.sync_value         (sync_q),
		.max_payload_length (max_len_q),
		.take               (take),
		.load_valid         (load_valid),
		.burst              (burst)
	);

	pfc_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.burst        (burst),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`PFC_ASSERT_SAME(a_last_is_ok, result_valid && result.last_of_packet, result.status == pfc_pkg::ST_OK)
	`PFC_ASSERT_SAME(a_err_clean, result_valid && (result.status != pfc_pkg::ST_OK), !result.last_of_packet && (result.out_byte == 8'h00))
	`PFC_ASSERT_NEXT(a_load_shows, load_valid && take, result_valid)

endmodule

[bench/packet_framer_crc16_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packet framer testbench
// Drives start and data beats through the framer, predicts the framed byte
// stream with CRC-16/MODBUS trailer and checks every result beat in order.
// ---------------------------------------------------------------------------
module packet_framer_crc16_core_tb;

	typedef struct {
		pfc_pkg::item_t   it;
		bit               typed;
		pfc_pkg::status_t st;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	pfc_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready = 1'b0;
	pfc_pkg::result_t result;
	logic             cfg_we;
	logic             cfg_index;
	logic [15:0]      cfg_data;

	// framer state as the predictor sees it
	logic [7:0]  sync_reg;
	logic [15:0] max_len_reg;
	logic [15:0] seq_no;
	logic [15:0] crc_acc;
	logic [15:0] bytes_left;
	bit          in_packet;

	pfc_pkg::result_t framed_q[$];
	pfc_pkg::result_t want;
	int        mismatches = 0;
	int        items_sent = 0;
	bit        hold_req = 1'b0;
	bit        hold_done = 1'b0;
	int        hold_left = 0;
	dir_row_t  dir_rows[15];

	wire calm = (items_sent >= 120) && (items_sent < 180);

	packet_framer_crc16_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("[packet_framer_crc16_core] ERROR");
		$finish;
	end

	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] c,
			input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		repeat (8) begin
			r = {1'b0, r[15:1]} ^ (r[0] ? pfc_pkg::CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		crc_acc = crc16_modbus_step(crc_acc, b);
		framed_q.push_back('{out_byte: b, last_of_packet: 1'b0, status: pfc_pkg::ST_OK});
	endfunction

	function automatic void close_packet();
		framed_q.push_back('{out_byte: crc_acc[7:0], last_of_packet: 1'b0,
			status: pfc_pkg::ST_OK});
		framed_q.push_back('{out_byte: crc_acc[15:8], last_of_packet: 1'b1,
			status: pfc_pkg::ST_OK});
		seq_no     = seq_no + 16'd1;
		crc_acc    = pfc_pkg::CRC_INIT;
		bytes_left = 16'd0;
		in_packet  = 1'b0;
	endfunction

	function automatic void push_error(input pfc_pkg::status_t st);
		framed_q.push_back('{out_byte: 8'h00, last_of_packet: 1'b0, status: st});
	endfunction

	function automatic void frame_predict(input pfc_pkg::item_t it);
		if (it.operation == pfc_pkg::OP_START) begin
			if (in_packet) begin
				push_error(pfc_pkg::ST_IN_PACKET);
			end else if (it.payload_length > max_len_reg) begin
				push_error(pfc_pkg::ST_TOO_LONG);
			end else begin
				crc_acc = pfc_pkg::CRC_INIT;
				emit_byte(sync_reg);
				emit_byte(it.payload_length[7:0]);
				emit_byte(it.payload_length[15:8]);
				emit_byte(seq_no[7:0]);
				emit_byte(seq_no[15:8]);
				bytes_left = it.payload_length;
				in_packet  = 1'b1;
				if (it.payload_length == 16'd0) begin
					close_packet();
				end
			end
		end else if (!in_packet) begin
			push_error(pfc_pkg::ST_NO_PACKET);
		end else begin
			emit_byte(it.payload_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0) begin
				close_packet();
			end
		end
	endfunction

	function automatic dir_row_t mk_row(input pfc_pkg::op_t op, input logic [15:0] len,
			input logic [7:0] b, input bit typed, input pfc_pkg::status_t st);
		dir_row_t r;
		r.it.operation      = op;
		r.it.payload_length = len;
		r.it.payload_byte   = b;
		r.typed             = typed;
		r.st                = st;
		return r;
	endfunction

	// Offer one beat, hold it until taken, then predict its results.
	task automatic send_item(input pfc_pkg::item_t it, input bit typed,
			input pfc_pkg::status_t st);
		while (!calm && $urandom_range(0, 99) < 22) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		frame_predict(it);
		if (typed) begin
			void'(framed_q.pop_back());
			push_error(st);
		end
		items_sent++;
		if (items_sent == 60) begin
			hold_req = 1'b1;
		end
	endtask

	task automatic wait_drained(input int tail);
		while (framed_q.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] sync, input logic [15:0] max_len);
		cfg_we    <= 1'b1;
		cfg_index <= pfc_pkg::CFG_SYNC;
		cfg_data  <= {8'($urandom), sync};
		@(posedge clk);
		cfg_index <= pfc_pkg::CFG_MAX_LEN;
		cfg_data  <= max_len;
		@(posedge clk);
		cfg_we      <= 1'b0;
		sync_reg    = sync;
		max_len_reg = max_len;
	endtask

	// Mostly whole packets with random content, with stray starts and bytes.
	task automatic run_phase(input int budget);
		int             n;
		int             cap;
		int             len;
		int             r;
		pfc_pkg::item_t it;
		n = 0;
		while (n < budget) begin
			r = $urandom_range(0, 99);
			it.payload_length = 16'($urandom);
			it.payload_byte   = 8'($urandom);
			if (r < 10) begin
				it.operation = pfc_pkg::OP_DATA;
				send_item(it, 1'b0, pfc_pkg::ST_OK);
				n++;
			end else if (r < 20 && max_len_reg != 16'hFFFF) begin
				it.operation      = pfc_pkg::OP_START;
				it.payload_length = 16'($urandom_range(int'(max_len_reg) + 1, 65535));
				send_item(it, 1'b0, pfc_pkg::ST_OK);
				n++;
			end else begin
				cap = (max_len_reg < 16'd8) ? int'(max_len_reg) : 8;
				if ($urandom_range(0, 9) == 0) begin
					cap = (max_len_reg < 16'd40) ? int'(max_len_reg) : 40;
				end
				len = $urandom_range(0, cap);
				it.operation      = pfc_pkg::OP_START;
				it.payload_length = 16'(len);
				send_item(it, 1'b0, pfc_pkg::ST_OK);
				n++;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 6) begin
						it.operation      = pfc_pkg::OP_START;
						it.payload_length = 16'($urandom);
						send_item(it, 1'b0, pfc_pkg::ST_OK);
						n++;
					end
					it.operation      = pfc_pkg::OP_DATA;
					it.payload_length = 16'($urandom);
					it.payload_byte   = 8'($urandom);
					send_item(it, 1'b0, pfc_pkg::ST_OK);
					n++;
				end
			end
		end
		item_valid <= 1'b0;
	endtask

	// Result side: check each beat, stall at random, hold off once for a long stretch.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (framed_q.size() == 0) begin
				$error("result beat with nothing expected: out_byte %0h status %0d",
					result.out_byte, result.status);
				mismatches++;
			end else begin
				want = framed_q.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte expected %0h got %0h", want.out_byte, result.out_byte);
					mismatches++;
				end
				if (result.last_of_packet !== want.last_of_packet) begin
					$error("last_of_packet expected %0b got %0b",
						want.last_of_packet, result.last_of_packet);
					mismatches++;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, result.status);
					mismatches++;
				end
			end
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 300;
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || ($urandom_range(0, 99) >= 22);
		end
	end

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_we       = 1'b0;
		cfg_index    = pfc_pkg::CFG_SYNC;
		cfg_data     = 16'h0000;
		sync_reg     = pfc_pkg::SYNC_RESET;
		max_len_reg  = pfc_pkg::MAX_LEN_RESET;
		seq_no       = 16'd0;
		crc_acc      = pfc_pkg::CRC_INIT;
		bytes_left   = 16'd0;
		in_packet    = 1'b0;

		dir_rows[0]  = mk_row(pfc_pkg::OP_DATA,  16'hFFFF, 8'hFF, 1'b1, pfc_pkg::ST_NO_PACKET);
		dir_rows[1]  = mk_row(pfc_pkg::OP_DATA,  16'h0000, 8'h00, 1'b1, pfc_pkg::ST_NO_PACKET);
		dir_rows[2]  = mk_row(pfc_pkg::OP_START, 16'd0,    8'hFF, 1'b0, pfc_pkg::ST_OK);
		dir_rows[3]  = mk_row(pfc_pkg::OP_START, 16'd1025, 8'h00, 1'b1, pfc_pkg::ST_TOO_LONG);
		dir_rows[4]  = mk_row(pfc_pkg::OP_START, 16'hFFFF, 8'hFF, 1'b1, pfc_pkg::ST_TOO_LONG);
		dir_rows[5]  = mk_row(pfc_pkg::OP_START, 16'd3,    8'h00, 1'b0, pfc_pkg::ST_OK);
		dir_rows[6]  = mk_row(pfc_pkg::OP_START, 16'd2,    8'h55, 1'b1, pfc_pkg::ST_IN_PACKET);
		dir_rows[7]  = mk_row(pfc_pkg::OP_DATA,  16'hFFFF, 8'h00, 1'b0, pfc_pkg::ST_OK);
		dir_rows[8]  = mk_row(pfc_pkg::OP_DATA,  16'h0000, 8'hFF, 1'b0, pfc_pkg::ST_OK);
		dir_rows[9]  = mk_row(pfc_pkg::OP_DATA,  16'h5555, 8'h80, 1'b0, pfc_pkg::ST_OK);
		dir_rows[10] = mk_row(pfc_pkg::OP_DATA,  16'hAAAA, 8'hA5, 1'b1, pfc_pkg::ST_NO_PACKET);
		dir_rows[11] = mk_row(pfc_pkg::OP_START, 16'd1,    8'h3C, 1'b0, pfc_pkg::ST_OK);
		dir_rows[12] = mk_row(pfc_pkg::OP_START, 16'hFFFF, 8'hFF, 1'b1, pfc_pkg::ST_IN_PACKET);
		dir_rows[13] = mk_row(pfc_pkg::OP_DATA,  16'h0001, 8'h7F, 1'b0, pfc_pkg::ST_OK);
		dir_rows[14] = mk_row(pfc_pkg::OP_START, 16'd0,    8'h01, 1'b0, pfc_pkg::ST_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].st);
		end
		item_valid <= 1'b0;
		wait_drained(4);

		write_config(8'h00, 16'd0);
		run_phase(20);
		wait_drained(4);

		write_config(8'hFF, 16'hFFFF);
		run_phase(50);
		wait_drained(4);

		for (int p = 0; p < 3; p++) begin
			write_config(8'($urandom), 16'($urandom_range(0, 24)));
			run_phase(45);
			wait_drained(4);
		end

		write_config(8'($urandom), pfc_pkg::MAX_LEN_RESET);
		run_phase(45);
		wait_drained(20);

		if (mismatches == 0 && framed_q.size() == 0) begin
			$display("[packet_framer_crc16_core] OK");
		end else begin
			$display("[packet_framer_crc16_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_frame.sv
hdl/pfc_serial.sv
hdl/packet_framer_crc16_core.sv
bench/packet_framer_crc16_core_tb.sv
